>>> rtl/core/cpp_pkg.sv
package cpp_pkg;

  localparam int unsigned CW = 16;
  localparam int unsigned IW = 10;
  localparam int unsigned DW = 17;

  typedef struct packed {
    logic start_edge;
    logic start_sqrt;
  } cmd_t;

  typedef struct packed {
    logic edge_done;
    logic sqrt_done;
  } sts_t;

endpackage

>>> rtl/core/closest_point_on_polygon_core.sv
// channel  | dir | tdata fields (low first)                    | tuser
// s_axis   | in  | query_x, query_y, vertex_x, vertex_y          | first_vertex
//          |     | tlast = last_vertex                           |
// m_axis   | out | closest_x, closest_y, start_index, end_index, | -
//          |     | distance, overflow                            |
// A vertex that forms an edge is held until its edge pass is done; the 16-step divider
// for t runs unless t clamps. A first vertex starts no edge pass of its own.
// A last vertex adds a closing edge pass and the 17-step square root. Reset clears
// the running polygon; the result holds until taken, input waits.
module closest_point_on_polygon_core #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // query_x, query_y, vertex_x, vertex_y
  input  logic        s_axis_tuser,  // first_vertex
  input  logic        s_axis_tlast,  // last_vertex
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // closest_x, closest_y, start, end, distance, overflow
);

  cpp_pkg::cmd_t cmd;
  cpp_pkg::sts_t sts;
  logic signed [cpp_pkg::CW-1:0] ax, ay, bx, by, qx, qy, px, py;
  logic [33:0] d2, sq;
  logic [cpp_pkg::DW-1:0] root;
  logic [69:0] od;

  assign m_axis_tdata = {2'b0, od};

  cpp_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .query_x_i(s_axis_tdata[15:0]), .query_y_i(s_axis_tdata[31:16]),
    .vertex_x_i(s_axis_tdata[47:32]), .vertex_y_i(s_axis_tdata[63:48]),
    .first_i(s_axis_tuser), .last_i(s_axis_tlast),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(od),
    .cmd_o(cmd), .sts_i(sts),
    .ax_o(ax), .ay_o(ay), .bx_o(bx), .by_o(by), .qx_o(qx), .qy_o(qy),
    .px_i(px), .py_i(py), .d2_i(d2), .sq_o(sq), .root_i(root)
  );

  cpp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .ax_i(ax), .ay_i(ay), .bx_i(bx), .by_i(by), .qx_i(qx), .qy_i(qy),
    .px_o(px), .py_o(py), .d2_o(d2), .sq_in_i(sq), .root_o(root)
  );

endmodule

>>> rtl/core/cpp_datapath.sv
module cpp_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cpp_pkg::cmd_t                   cmd_i,
  output cpp_pkg::sts_t                   sts_o,
  input  logic signed [cpp_pkg::CW-1:0]   ax_i,
  input  logic signed [cpp_pkg::CW-1:0]   ay_i,
  input  logic signed [cpp_pkg::CW-1:0]   bx_i,
  input  logic signed [cpp_pkg::CW-1:0]   by_i,
  input  logic signed [cpp_pkg::CW-1:0]   qx_i,
  input  logic signed [cpp_pkg::CW-1:0]   qy_i,
  output logic signed [cpp_pkg::CW-1:0]   px_o,
  output logic signed [cpp_pkg::CW-1:0]   py_o,
  output logic        [33:0]              d2_o,
  input  logic        [33:0]              sq_in_i,
  output logic        [cpp_pkg::DW-1:0]   root_o
);

  localparam int CW = cpp_pkg::CW;

  typedef enum logic [2:0] {
    E_IDLE, E_DIFF, E_PROD, E_DIV, E_POINT, E_DIST, E_SUM
  } est_e;

  est_e est_q;
  logic signed [16:0] abx_q, aby_q, apx_q, apy_q;
  logic signed [33:0] m0_q, m1_q, m2_q, m3_q;
  logic [33:0] len_q;
  logic [34:0] rem_q;
  logic [16:0] t_q;
  logic [4:0]  cnt_q;
  logic signed [16:0] dx_q, dy_q;
  logic edge_done_q;
  logic signed [35:0] rpx, rpy;
  logic signed [34:0] dotw, lenw;
  logic [34:0] rsh;

  assign dotw = 35'(m0_q) + 35'(m1_q);
  assign lenw = 35'(m2_q) + 35'(m3_q);
  assign rsh  = {rem_q[33:0], 1'b0};
  assign rpx  = 36'(m0_q) + 36'sd32768;
  assign rpy  = 36'(m1_q) + 36'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= E_IDLE;
      edge_done_q <= 1'b0;
    end else begin
      edge_done_q <= 1'b0;
      case (est_q)
        E_IDLE: begin
          if (cmd_i.start_edge) begin
            abx_q <= 17'(bx_i) - 17'(ax_i);
            aby_q <= 17'(by_i) - 17'(ay_i);
            apx_q <= 17'(qx_i) - 17'(ax_i);
            apy_q <= 17'(qy_i) - 17'(ay_i);
            est_q <= E_DIFF;
          end
        end
        E_DIFF: begin
          m0_q <= 34'(apx_q * abx_q);
          m1_q <= 34'(apy_q * aby_q);
          m2_q <= 34'(abx_q * abx_q);
          m3_q <= 34'(aby_q * aby_q);
          est_q <= E_PROD;
        end
        E_PROD: begin
          len_q <= lenw[33:0];
          rem_q <= 35'(dotw[33:0]);
          cnt_q <= '0;
          if (lenw == 0 || dotw <= 0) begin
            t_q <= '0;
            est_q <= E_POINT;
          end else if (dotw >= lenw) begin
            t_q <= 17'h10000;
            est_q <= E_POINT;
          end else begin
            t_q <= '0;
            est_q <= E_DIV;
          end
        end
        E_DIV: begin
          if (rsh >= 35'(len_q)) begin
            rem_q <= rsh - 35'(len_q);
            t_q <= {t_q[15:0], 1'b1};
          end else begin
            rem_q <= rsh;
            t_q <= {t_q[15:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) est_q <= E_POINT;
        end
        E_POINT: begin
          m0_q <= 34'(abx_q * $signed({1'b0, t_q}));
          m1_q <= 34'(aby_q * $signed({1'b0, t_q}));
          est_q <= E_DIST;
        end
        E_DIST: begin
          px_o <= CW'(ax_i + CW'(rpx >>> 16));
          py_o <= CW'(ay_i + CW'(rpy >>> 16));
          dx_q <= 17'(qx_i) - 17'(ax_i) - 17'(rpx >>> 16);
          dy_q <= 17'(qy_i) - 17'(ay_i) - 17'(rpy >>> 16);
          est_q <= E_SUM;
        end
        E_SUM: begin
          d2_o <= 34'(dx_q * dx_q) + 34'(dy_q * dy_q);
          edge_done_q <= 1'b1;
          est_q <= E_IDLE;
        end
        default: est_q <= E_IDLE;
      endcase
    end
  end

  // bitwise integer square root
  logic [33:0] sv_q;
  logic [33:0] sr_q;
  logic [33:0] sb_q;
  logic        sbusy_q, sdone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sdone_q <= 1'b0;
    end else begin
      sdone_q <= 1'b0;
      if (cmd_i.start_sqrt) begin
        sv_q <= sq_in_i;
        sr_q <= '0;
        sb_q <= 34'h1 << 32;
        sbusy_q <= 1'b1;
      end else if (sbusy_q) begin
        if (sv_q >= sr_q + sb_q) begin
          sv_q <= sv_q - (sr_q + sb_q);
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
        if (sb_q == 34'd1) begin
          sbusy_q <= 1'b0;
          sdone_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = sr_q[cpp_pkg::DW-1:0];
  assign sts_o.edge_done = edge_done_q;
  assign sts_o.sqrt_done = sdone_q;

endmodule

>>> rtl/core/cpp_ctrl.sv
module cpp_ctrl #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [cpp_pkg::CW-1:0]  query_x_i,
  input  logic signed [cpp_pkg::CW-1:0]  query_y_i,
  input  logic signed [cpp_pkg::CW-1:0]  vertex_x_i,
  input  logic signed [cpp_pkg::CW-1:0]  vertex_y_i,
  input  logic                           first_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [69:0]                    out_data_o,
  output cpp_pkg::cmd_t                  cmd_o,
  input  cpp_pkg::sts_t                  sts_i,
  output logic signed [cpp_pkg::CW-1:0]  ax_o,
  output logic signed [cpp_pkg::CW-1:0]  ay_o,
  output logic signed [cpp_pkg::CW-1:0]  bx_o,
  output logic signed [cpp_pkg::CW-1:0]  by_o,
  output logic signed [cpp_pkg::CW-1:0]  qx_o,
  output logic signed [cpp_pkg::CW-1:0]  qy_o,
  input  logic signed [cpp_pkg::CW-1:0]  px_i,
  input  logic signed [cpp_pkg::CW-1:0]  py_i,
  input  logic [33:0]                    d2_i,
  output logic [33:0]                    sq_o,
  input  logic [cpp_pkg::DW-1:0]         root_i
);

  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EDGE, S_WAIT, S_CLOSE, S_CWAIT, S_SQRT, S_SWAIT, S_OUT
  } st_e;

  st_e st_q;
  logic [VCW-1:0] cnt_q;
  logic signed [cpp_pkg::CW-1:0] fx_q, fy_q, vx_q, vy_q;
  logic [33:0] best_q;
  logic signed [cpp_pkg::CW-1:0] bpx_q, bpy_q;
  logic [cpp_pkg::IW-1:0] bs_q, be_q, si_q, ei_q;
  logic ovf_q, last_q;
  cpp_pkg::cmd_t cmd_q;

  assign in_ready_o = (st_q == S_IDLE);
  assign cmd_o = cmd_q;
  assign sq_o = best_q;
  assign bx_o = vx_q;
  assign by_o = vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      cmd_q <= '0;
      out_valid_o <= 1'b0;
      ovf_q <= 1'b0;
      best_q <= '1;
      qx_o <= '0; qy_o <= '0; fx_q <= '0; fy_q <= '0;
      ax_o <= '0; ay_o <= '0; vx_q <= '0; vy_q <= '0;
      bpx_q <= '0; bpy_q <= '0; bs_q <= '0; be_q <= '0;
      si_q <= '0; ei_q <= '0; last_q <= 1'b0;
      out_data_o <= '0;
    end else begin
      cmd_q <= '0;
      case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q <= last_i;
            if (first_i || cnt_q == '0) begin
              qx_o <= query_x_i; qy_o <= query_y_i;
              fx_q <= vertex_x_i; fy_q <= vertex_y_i;
              ax_o <= vertex_x_i; ay_o <= vertex_y_i;
              cnt_q <= VCW'(1);
              best_q <= '1;
              bpx_q <= '0; bpy_q <= '0; bs_q <= '0; be_q <= '0;
              ovf_q <= 1'b0;
              st_q <= last_i ? S_CLOSE : S_IDLE;
            end else if (VCW'(cnt_q) < VCW'(MAX_VERTICES)) begin
              vx_q <= vertex_x_i; vy_q <= vertex_y_i;
              si_q <= cpp_pkg::IW'(cnt_q - VCW'(1));
              ei_q <= cpp_pkg::IW'(cnt_q);
              cmd_q.start_edge <= 1'b1;
              st_q <= S_WAIT;
            end else begin
              ovf_q <= 1'b1;
              st_q <= last_i ? S_CLOSE : S_IDLE;
            end
          end
        end
        S_WAIT: begin
          if (sts_i.edge_done) begin
            if (d2_i < best_q) begin
              best_q <= d2_i; bpx_q <= px_i; bpy_q <= py_i;
              bs_q <= si_q; be_q <= ei_q;
            end
            ax_o <= vx_q; ay_o <= vy_q;
            cnt_q <= cnt_q + VCW'(1);
            st_q <= last_q ? S_CLOSE : S_IDLE;
          end
        end
        S_CLOSE: begin
          vx_q <= fx_q; vy_q <= fy_q;
          si_q <= cpp_pkg::IW'(cnt_q - VCW'(1));
          ei_q <= '0;
          st_q <= S_EDGE;
        end
        S_EDGE: begin
          cmd_q.start_edge <= 1'b1;
          st_q <= S_CWAIT;
        end
        S_CWAIT: begin
          if (sts_i.edge_done) begin
            if (d2_i < best_q) begin
              best_q <= d2_i; bpx_q <= px_i; bpy_q <= py_i;
              bs_q <= si_q; be_q <= ei_q;
            end
            st_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          cmd_q.start_sqrt <= 1'b1;
          st_q <= S_SWAIT;
        end
        S_SWAIT: begin
          if (sts_i.sqrt_done) begin
            out_data_o <= {ovf_q, root_i, be_q, bs_q, bpy_q, bpx_q};
            out_valid_o <= 1'b1;
            cnt_q <= '0;
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/closest_point_on_polygon_core_tb.sv
module closest_point_on_polygon_core_tb;

  localparam int unsigned MAX_VTX = 1024;
  localparam logic [33:0] SQ_INIT = '1;

  typedef struct packed {
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] vx;
    logic [15:0] vy;
    logic        first;
    logic        last;
  } vertex_t;

  typedef struct packed {
    logic        ovf;
    logic [16:0] dst;
    logic [9:0]  ei;
    logic [9:0]  si;
    logic [15:0] cy;
    logic [15:0] cx;
  } nearest_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  closest_point_on_polygon_core #(.MAX_VERTICES(MAX_VTX)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  vertex_t  vertex_q[$];
  nearest_t nearest_q[$];
  int       err_cnt;
  bit       calm;
  bit       stim_done;

  longint   qp_x, qp_y, fp_x, fp_y, pp_x, pp_y, bp_x, bp_y;
  int       vcnt;
  longint   best_d2;
  int       best_s, best_e;
  bit       ovf_seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic try_edge(longint ax, longint ay, longint bx, longint by, int s, int e);
    longint abx, aby, apx, apy, len2, dotp, t, px, py, d2;
    abx = bx - ax;
    aby = by - ay;
    apx = qp_x - ax;
    apy = qp_y - ay;
    len2 = abx * abx + aby * aby;
    dotp = apx * abx + apy * aby;
    if (len2 == 0 || dotp <= 0) t = 0;
    else if (dotp >= len2) t = 65536;
    else t = (dotp * 65536) / len2;
    px = ax + round16(abx * t);
    py = ay + round16(aby * t);
    d2 = (qp_x - px) * (qp_x - px) + (qp_y - py) * (qp_y - py);
    if (d2 < best_d2) begin
      best_d2 = d2;
      bp_x = px;
      bp_y = py;
      best_s = s;
      best_e = e;
    end
  endtask

  task automatic predict_nearest(vertex_t v);
    longint vx, vy;
    nearest_t r;
    vx = longint'($signed(v.vx));
    vy = longint'($signed(v.vy));
    if (v.first || vcnt == 0) begin
      qp_x = longint'($signed(v.qx));
      qp_y = longint'($signed(v.qy));
      fp_x = vx;
      fp_y = vy;
      pp_x = vx;
      pp_y = vy;
      vcnt = 1;
      best_d2 = longint'(SQ_INIT);
      bp_x = 0;
      bp_y = 0;
      best_s = 0;
      best_e = 0;
      ovf_seen = 1'b0;
    end else if (vcnt < MAX_VTX) begin
      try_edge(pp_x, pp_y, vx, vy, vcnt - 1, vcnt);
      pp_x = vx;
      pp_y = vy;
      vcnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (v.last) begin
      try_edge(pp_x, pp_y, fp_x, fp_y, vcnt - 1, 0);
      r.cx = bp_x[15:0];
      r.cy = bp_y[15:0];
      r.si = best_s[9:0];
      r.ei = best_e[9:0];
      r.dst = 17'(int_sqrt(best_d2));
      r.ovf = ovf_seen;
      nearest_q.insert(nearest_q.size(), r);
      vcnt = 0;
    end
  endtask

  function automatic logic [15:0] rand_coord(int span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_vertex(logic [15:0] qx, logic [15:0] qy, logic [15:0] vx,
                            logic [15:0] vy, logic first, logic last);
    vertex_t v;
    v.qx = qx;
    v.qy = qy;
    v.vx = vx;
    v.vy = vy;
    v.first = first;
    v.last = last;
    vertex_q.insert(vertex_q.size(), v);
  endtask

  task automatic add_polygon(int n, int span, bit explicit_first);
    logic [15:0] qx, qy;
    qx = rand_coord(span);
    qy = rand_coord(span);
    for (int i = 0; i < n; i++) begin
      add_vertex(i == 0 ? qx : 16'($urandom), i == 0 ? qy : 16'($urandom),
                 rand_coord(span), rand_coord(span),
                 i == 0 ? explicit_first : 1'($urandom_range(0, 19) == 0 ? 0 : 0),
                 i == n - 1);
    end
  endtask

  initial begin
    int n;
    add_vertex(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b1, 1'b1);
    add_vertex(16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    add_vertex(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
    add_vertex(16'h0010, 16'h0020, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0040, 16'h0000, 1'b0, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0040, 16'h0040, 1'b0, 1'b1);
    add_vertex(16'h0005, 16'h0005, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0010, 16'h0000, 1'b0, 1'b0);
    add_vertex(16'h0100, 16'h0100, 16'hff00, 16'h0100, 1'b1, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0100, 16'hff00, 1'b0, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'hff00, 16'hff00, 1'b0, 1'b1);
    add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0020, 16'h0000, 1'b0, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0020, 16'h0020, 1'b0, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0020, 1'b0, 1'b1);
    add_vertex(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h8000, 16'h7fff, 1'b0, 1'b1);
    for (int i = 0; i < 1030; i++)
      add_vertex(16'($urandom), 16'($urandom), rand_coord(4000), rand_coord(4000),
                 i == 0, i == 1029);
    while (vertex_q.size() < 1450) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      case ($urandom_range(0, 3))
        0: add_polygon(n, 0, 1'($urandom));
        1: add_polygon(n, 64, 1'($urandom));
        default: add_polygon(n, 2000, 1'($urandom));
      endcase
      if ($urandom_range(0, 15) == 0)
        add_vertex(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   1'b1, 1'b0);
    end
  end

  int s_idle, m_idle;

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t v;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
      s_axis_tlast <= 1'b0;
      s_idle <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_nearest(vertex_q.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_idle > 0) begin
          s_idle <= s_idle - 1;
          s_axis_tvalid <= 1'b0;
        end else if (vertex_q.size() > 0) begin
          v = vertex_q[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {v.vy, v.vx, v.qy, v.qx};
          s_axis_tuser <= v.first;
          s_axis_tlast <= v.last;
          if (!calm && $urandom_range(0, 7) == 0) s_idle <= int'($urandom_range(1, 9));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      calm <= vertex_q.size() < 300;
      stim_done <= vertex_q.size() == 0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    nearest_t exp_r, got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      m_idle <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[69:0];
        if (nearest_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = nearest_q.pop_front();
          if (got !== exp_r) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: exp x=%h y=%h s=%0d e=%0d d=%0d o=%b",
                        " got x=%h y=%h s=%0d e=%0d d=%0d o=%b"},
                       exp_r.cx, exp_r.cy, exp_r.si, exp_r.ei, exp_r.dst, exp_r.ovf,
                       got.cx, got.cy, got.si, got.ei, got.dst, got.ovf);
          end
        end
      end
      if (m_idle > 0) begin
        m_idle <= m_idle - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) m_idle <= int'($urandom_range(1, 9));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    wait (stim_done && !s_axis_tvalid && nearest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && !m_axis_tvalid) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> closest_point_on_polygon_core.f
rtl/core/cpp_pkg.sv
rtl/core/cpp_datapath.sv
rtl/core/cpp_ctrl.sv
rtl/core/closest_point_on_polygon_core.sv
tb/closest_point_on_polygon_core_tb.sv
